@@ hdl/tst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_pkg
// Shared types and constants of the topic subscription table.
// ----------------------------------------------------------------------------
package tst_pkg;

   localparam int CMD_W    = 2;
   localparam int KEY_W    = 64;
   localparam int HOST_W   = 16;
   localparam int SEQ_W    = 64;
   localparam int STATUS_W = 3;

   localparam int DEF_ENTRIES   = 64;
   localparam int DEF_HOST_BITS = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_VISIT  = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_UPDATED  = 3'd0,
      STS_INSERTED = 3'd1,
      STS_FULL     = 3'd2,
      STS_REMAINS  = 3'd3,
      STS_EMPTY    = 3'd4,
      STS_MATCH    = 3'd5,
      STS_NOMATCH  = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      status_type        status;
      logic [HOST_W-1:0] match_host;
      logic [SEQ_W-1:0]  match_seqno;
      logic              last;
   } rsp_type;

endpackage

@@ hdl/tst_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_req_if
// Request channel: command, topic, host and sequence bounds.
// ----------------------------------------------------------------------------
interface tst_req_if;
   import tst_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [KEY_W-1:0]  topic_key;
   logic [HOST_W-1:0] host;
   logic [SEQ_W-1:0]  seqno_low;
   logic [SEQ_W-1:0]  seqno_high;

   modport source (output valid, cmd, topic_key, host, seqno_low, seqno_high,
                   input ready);
   modport sink (input valid, cmd, topic_key, host, seqno_low, seqno_high,
                 output ready);
endinterface

@@ hdl/tst_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_rsp_if
// Response channel: status, visited subscriber and last mark.
// ----------------------------------------------------------------------------
interface tst_rsp_if;
   import tst_pkg::*;

   logic              valid;
   logic              ready;
   status_type        status;
   logic [HOST_W-1:0] match_host;
   logic [SEQ_W-1:0]  match_seqno;
   logic              last;

   modport source (output valid, status, match_host, match_seqno, last,
                   input ready);
   modport sink (input valid, status, match_host, match_seqno, last,
                 output ready);
endinterface

@@ hdl/tst_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/tst_rsp_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_rsp_reg
// Output register between the scan engine and the response channel.
// ----------------------------------------------------------------------------
module tst_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tst_pkg::rsp_type push_data,
   output logic             out_free,
   tst_rsp_if.source        rsp_ch
);
   import tst_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign out_free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.status      = data_ff.status;
   assign rsp_ch.match_host  = data_ff.match_host;
   assign rsp_ch.match_seqno = data_ff.match_seqno;
   assign rsp_ch.last        = data_ff.last;
endmodule

@@ hdl/tst_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tst_engine
// Scan sequencer: clears the table, walks every slot per request and
// updates the slot table through the RAM write port.
// ----------------------------------------------------------------------------
module tst_engine #(
   parameter int ENTRIES   = tst_pkg::DEF_ENTRIES,
   parameter int HOST_BITS = tst_pkg::DEF_HOST_BITS,
   parameter int WORD_W    = 1 + tst_pkg::KEY_W + HOST_BITS + tst_pkg::SEQ_W
) (
   input  logic                       clock,
   input  logic                       reset,
   tst_req_if.sink                    req_ch,
   output logic                       ram_wr_en,
   output logic [$clog2(ENTRIES)-1:0] ram_wr_addr,
   output logic [WORD_W-1:0]          ram_wr_data,
   output logic                       ram_rd_en,
   output logic [$clog2(ENTRIES)-1:0] ram_rd_addr,
   input  logic [WORD_W-1:0]          ram_rd_data,
   output logic                       rsp_push,
   output tst_pkg::rsp_type           rsp_data,
   input  logic                       out_free
);
   import tst_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CNT_W = IDX_W + 1;

   state_type state_ff, state_in;

   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [HOST_BITS-1:0] host_ff, host_in;
   logic [SEQ_W-1:0]     lo_ff, lo_in;
   logic [SEQ_W-1:0]     hi_ff, hi_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 ev_vld_ff, ev_vld_in;
   logic [IDX_W-1:0]     ev_idx_ff, ev_idx_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     slot_ff, slot_in;
   logic                 free_vld_ff, free_vld_in;
   logic [IDX_W-1:0]     free_idx_ff, free_idx_in;
   logic                 remains_ff, remains_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [HOST_BITS-1:0] pend_host_ff, pend_host_in;
   logic [SEQ_W-1:0]     pend_seq_ff, pend_seq_in;

   logic                 accept;
   logic                 known_cmd;
   logic                 in_scan;
   logic                 issue;
   logic                 adv;
   logic                 e_valid;
   logic [KEY_W-1:0]     e_key;
   logic [HOST_BITS-1:0] e_host;
   logic [SEQ_W-1:0]     e_seq;
   logic                 topic_hit;
   logic                 pair_hit;
   logic                 free_hit;
   logic                 range_hit;
   logic                 is_add;
   logic                 is_remove;
   logic                 is_visit;

   // slot word layout: valid, topic, host, seqno
   assign e_valid = ram_rd_data[WORD_W-1];
   assign e_key   = ram_rd_data[SEQ_W+HOST_BITS +: KEY_W];
   assign e_host  = ram_rd_data[SEQ_W +: HOST_BITS];
   assign e_seq   = ram_rd_data[SEQ_W-1:0];

   assign is_add    = (cmd_ff == CMD_ADD);
   assign is_remove = (cmd_ff == CMD_REMOVE);
   assign is_visit  = (cmd_ff == CMD_VISIT);

   assign topic_hit = ev_vld_ff && e_valid && (e_key == key_ff);
   assign pair_hit  = topic_hit && (e_host == host_ff);
   assign free_hit  = ev_vld_ff && !e_valid;
   assign range_hit = topic_hit && (e_seq >= lo_ff) && (e_seq <= hi_ff);

   assign accept    = req_ch.valid && req_ch.ready;
   assign known_cmd = (req_ch.cmd == CMD_ADD) || (req_ch.cmd == CMD_REMOVE) ||
                      (req_ch.cmd == CMD_VISIT);
   assign in_scan   = (state_ff == ST_SCAN);
   // hold the scan while a second visit hit has nowhere to go
   assign adv       = !(in_scan && is_visit && range_hit && pend_vld_ff && !out_free);
   assign issue     = in_scan && adv && (cnt_ff < CNT_W'(ENTRIES));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (cnt_ff == CNT_W'(ENTRIES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept && known_cmd) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (adv && !issue) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ch.ready = (state_ff == ST_IDLE);
      ram_rd_en    = issue;
      ram_rd_addr  = cnt_ff[IDX_W-1:0];
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cnt_ff[IDX_W-1:0];
      ram_wr_data  = '0;
      rsp_push     = 1'b0;
      rsp_data     = '{status: STS_MATCH, match_host: '0, match_seqno: '0, last: 1'b0};
      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
         end
         ST_SCAN: begin
            if (adv && is_remove && pair_hit && !found_ff) begin
               // drop the matching pair
               ram_wr_en   = 1'b1;
               ram_wr_addr = ev_idx_ff;
               ram_wr_data = {1'b0, key_ff, host_ff, e_seq};
            end
            if (adv && is_visit && range_hit && pend_vld_ff) begin
               rsp_push              = 1'b1;
               rsp_data.match_host   = HOST_W'(pend_host_ff);
               rsp_data.match_seqno  = pend_seq_ff;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_push      = 1'b1;
               rsp_data.last = 1'b1;
               if (is_add) begin
                  ram_wr_data = {1'b1, key_ff, host_ff, lo_ff};
                  if (found_ff) begin
                     rsp_data.status = STS_UPDATED;
                     ram_wr_en       = 1'b1;
                     ram_wr_addr     = slot_ff;
                  end else if (free_vld_ff) begin
                     rsp_data.status = STS_INSERTED;
                     ram_wr_en       = 1'b1;
                     ram_wr_addr     = free_idx_ff;
                  end else begin
                     rsp_data.status = STS_FULL;
                  end
               end else if (is_remove) begin
                  rsp_data.status = remains_ff ? STS_REMAINS : STS_EMPTY;
               end else if (pend_vld_ff) begin
                  rsp_data.match_host  = HOST_W'(pend_host_ff);
                  rsp_data.match_seqno = pend_seq_ff;
               end else begin
                  rsp_data.status = STS_NOMATCH;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      host_in      = host_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      cnt_in       = cnt_ff;
      ev_vld_in    = ev_vld_ff;
      ev_idx_in    = ev_idx_ff;
      found_in     = found_ff;
      slot_in      = slot_ff;
      free_vld_in  = free_vld_ff;
      free_idx_in  = free_idx_ff;
      remains_in   = remains_ff;
      pend_vld_in  = pend_vld_ff;
      pend_host_in = pend_host_ff;
      pend_seq_in  = pend_seq_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = (cnt_ff == CNT_W'(ENTRIES - 1)) ? '0 : cnt_ff + CNT_W'(1);
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in      = req_ch.cmd;
               key_in      = req_ch.topic_key;
               host_in     = HOST_BITS'(req_ch.host);
               lo_in       = req_ch.seqno_low;
               hi_in       = req_ch.seqno_high;
               cnt_in      = '0;
               ev_vld_in   = 1'b0;
               found_in    = 1'b0;
               free_vld_in = 1'b0;
               remains_in  = 1'b0;
               pend_vld_in = 1'b0;
            end
         end
         ST_SCAN: begin
            if (adv) begin
               ev_vld_in = issue;
               if (issue) begin
                  ev_idx_in = cnt_ff[IDX_W-1:0];
                  cnt_in    = cnt_ff + CNT_W'(1);
               end
               if (pair_hit && !found_ff) begin
                  found_in = 1'b1;
                  slot_in  = ev_idx_ff;
               end else if (is_remove && topic_hit) begin
                  remains_in = 1'b1;
               end
               if (is_add && free_hit && !free_vld_ff) begin
                  free_vld_in = 1'b1;
                  free_idx_in = ev_idx_ff;
               end
               if (is_visit && range_hit) begin
                  pend_vld_in  = 1'b1;
                  pend_host_in = e_host;
                  pend_seq_in  = e_seq;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) pend_vld_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         cnt_ff      <= '0;
         ev_vld_ff   <= 1'b0;
         found_ff    <= 1'b0;
         free_vld_ff <= 1'b0;
         remains_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         ev_vld_ff   <= ev_vld_in;
         found_ff    <= found_in;
         free_vld_ff <= free_vld_in;
         remains_ff  <= remains_in;
         pend_vld_ff <= pend_vld_in;
      end
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      host_ff      <= host_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      ev_idx_ff    <= ev_idx_in;
      slot_ff      <= slot_in;
      free_idx_ff  <= free_idx_in;
      pend_host_ff <= pend_host_in;
      pend_seq_ff  <= pend_seq_in;
   end
endmodule

@@ hdl/topic_subscription_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// topic_subscription_table_unit
// Flat subscription table: add or update, remove, and ranged visit of the
// subscribers of one topic, held in a single slot RAM.
// ----------------------------------------------------------------------------
//  channel  | dir | moves
//  ---------+-----+------------------------------------------------------
//  req_ch   | in  | cmd, topic_key, host, seqno_low, seqno_high
//  rsp_ch   | out | status, match_host, match_seqno, last
//
// An item is worked in steps: accept, one RAM read per slot checked from
// the registered read data, and a finish step that writes an added slot
// and issues the final result. Visit hits wait on the response register
// when the consumer stalls. After reset a clearing pass writes every slot
// empty, with req_ch.ready low. One item is worked at a time.
// ----------------------------------------------------------------------------
module topic_subscription_table_unit #(
   parameter int ENTRIES   = tst_pkg::DEF_ENTRIES,
   parameter int HOST_BITS = tst_pkg::DEF_HOST_BITS
) (
   input  logic      clock,
   input  logic      reset,
   tst_req_if.sink   req_ch,
   tst_rsp_if.source rsp_ch
);
   import tst_pkg::*;

   localparam int IDX_W  = $clog2(ENTRIES);
   localparam int WORD_W = 1 + KEY_W + HOST_BITS + SEQ_W;

   logic              ram_wr_en;
   logic [IDX_W-1:0]  ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [IDX_W-1:0]  ram_rd_addr;
   logic [WORD_W-1:0] ram_rd_data;
   logic              rsp_push;
   rsp_type           rsp_data;
   logic              out_free;

   tst_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tst_engine #(
      .ENTRIES   (ENTRIES),
      .HOST_BITS (HOST_BITS),
      .WORD_W    (WORD_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_data),
      .out_free    (out_free)
   );

   tst_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_data),
      .out_free  (out_free),
      .rsp_ch    (rsp_ch)
   );
endmodule
